/* rtl/circular_double_ended_queue_macros.svh */
// Assertion macros shared by the queue RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Clocked on clk, masked while rst is high.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cdq_pkg.sv */
// Types and codes of the circular double-ended queue.
package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_QUERY      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  localparam logic signed [DATA_W-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] data_in;
  } cdq_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
  } cdq_rsp_t;

endpackage

/* rtl/cdq_store.sv */
// Element store: one write port, two registered read ports with write bypass.
module cdq_store #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]        rd_data_a,
  output logic [DATA_W-1:0]        rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-during-write to the same slot returns the new value
  always_ff @(posedge clk) begin
    rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
    rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
  end

endmodule

/* rtl/circular_double_ended_queue.sv */
// Top level of the circular double-ended queue.
//
//   channel  dir  handshake            item
//   cmd      in   cmd_valid/cmd_stall  cdq_cmd_t (mode, data_in)
//   rsp      out  rsp_valid/rsp_stall  cdq_rsp_t (status, values, is_empty, occupancy)
//
// One item per cycle while rsp does not stall; accept sets a_valid, then rsp_valid.
// Pointers update at accept; the store reads the next front and rear slots
// into registers on the same edge, so the following item sees them at once.
// Reset clears pointers, count and valids; the store itself is not cleared.
// cmd_stall rises only when both the read stage and rsp hold items and rsp stalls.
`include "circular_double_ended_queue_macros.svh"

module circular_double_ended_queue #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  cdq_pkg::cdq_cmd_t cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output cdq_pkg::cdq_rsp_t rsp
);

  import cdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] rd_head, rd_tail;

  logic                     a_valid;
  logic [1:0]               a_status;
  logic signed [DATA_W-1:0] a_popped;
  logic                     a_empty;
  logic [OCC_W-1:0]         a_occ;

  logic                     cmd_acc, a_move;
  logic                     is_push, is_pop;
  logic [1:0]               status_c;
  logic signed [DATA_W-1:0] popped_c;
  logic [CW+OCC_W-1:0]      occ_wide;

  assign a_move    = a_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = a_valid && !a_move;
  assign cmd_acc   = cmd_valid && !cmd_stall;

  assign is_push = (cmd.mode == MODE_PUSH_FRONT) || (cmd.mode == MODE_PUSH_REAR);
  assign is_pop  = (cmd.mode == MODE_POP_FRONT)  || (cmd.mode == MODE_POP_REAR);

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    wr_en = 1'b0;
    wr_addr = head;
    status_c = ST_OK;
    popped_c = NO_VALUE;
    if (cmd_acc) begin
      if (is_push) begin
        if (count == FULL) begin
          status_c = ST_OVER;
        end else if (count == '0) begin
          // empty queue restarts at slot zero
          head_next = '0;
          tail_next = '0;
          wr_addr = '0;
          wr_en = 1'b1;
          count_next = ONE_C;
        end else if (cmd.mode == MODE_PUSH_FRONT) begin
          head_next = (head == '0) ? LAST : head - 1'b1;
          wr_addr = head_next;
          wr_en = 1'b1;
          count_next = count + 1'b1;
        end else begin
          tail_next = (tail == LAST) ? '0 : tail + 1'b1;
          wr_addr = tail_next;
          wr_en = 1'b1;
          count_next = count + 1'b1;
        end
      end else if (is_pop) begin
        if (count == '0) begin
          status_c = ST_UNDER;
        end else if (cmd.mode == MODE_POP_FRONT) begin
          popped_c = rd_head;
          count_next = count - 1'b1;
          if (count != ONE_C) begin
            head_next = (head == LAST) ? '0 : head + 1'b1;
          end
        end else begin
          popped_c = rd_tail;
          count_next = count - 1'b1;
          if (count != ONE_C) begin
            tail_next = (tail == '0) ? LAST : tail - 1'b1;
          end
        end
      end
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_next};

  cdq_store #(
    .DEPTH  (CAPACITY),
    .DATA_W (DATA_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (cmd.data_in),
    .rd_addr_a (head_next),
    .rd_addr_b (tail_next),
    .rd_data_a (rd_head),
    .rd_data_b (rd_tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
    end
  end

  // read stage: control fields wait here while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd_acc) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      a_status <= status_c;
      a_popped <= popped_c;
      a_empty <= (count_next == '0);
      a_occ <= occ_wide[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (a_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      rsp.status <= a_status;
      rsp.popped_value <= a_popped;
      rsp.front_value <= a_empty ? NO_VALUE : rd_head;
      rsp.rear_value <= a_empty ? NO_VALUE : rd_tail;
      rsp.is_empty <= a_empty;
      rsp.occupancy <= a_occ;
    end
  end

  `CDQ_ASSERT_ALWAYS(a_count_bound, !rst |-> count <= FULL, "element count above capacity")
  `CDQ_ASSERT(a_idle_hold, !cmd_acc |=> $stable({count, head, tail}), "state moved with no item")
  `CDQ_ASSERT(a_full_push, cmd_acc && is_push && (count == FULL) |=> (a_status == ST_OVER) && $stable(count), "push into full queue not refused")
  `CDQ_ASSERT(a_pop_count, cmd_acc && is_pop && (count != '0) |=> count == $past(count) - 1'b1, "pop did not remove one element")
  `CDQ_ASSERT(a_stall_cause, cmd_stall |-> a_valid && rsp_valid && rsp_stall, "input stalled with room downstream")

endmodule
